FILE: rtl/core/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Payload types, queue entry type, round constants and initial hash values.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Queue entry from the front end: one byte for the block buffer, and flags
  // telling the back end when the block is complete and whether it is final.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       end_block;
    logic       end_msg;
  } byte_op_t;

  localparam int QDepth = 4;
  localparam int QIdxW  = $clog2(QDepth);

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

endpackage

FILE: rtl/core/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256: absorb requests feed bytes, a finish request pads the
// message and returns eight digest words.
// ----------------------------------------------------------------------------
//  channel | ports                        | carries
//  in      | in_valid/in_ready/in_data    | command, data_byte
//  out     | out_valid/out_ready/out_data | digest_word, word_index, last_word
//
// Each accepted data byte goes straight into the queue; the back end fills
// each 64-byte block with one queue pop per byte, then runs the 64 rounds
// and an add step in the single round unit, which sets the sustained rate.
// A finish request holds in_ready low while the front end generates padding
// (up to 72 bytes); digest words follow one per accepted out request.
// Reset (rst_n, synchronous) restores the initial hash and clears counters.
// The four-entry queue lets the front end accept up to four bytes while rounds run.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sha_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sha_pkg::out_item_t out_data
);
  import sha_pkg::*;

  logic     q_push, q_full, q_pop, q_empty;
  byte_op_t q_wdata, q_rdata;

  sha_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_push, .q_data(q_wdata), .q_full
  );

  sha_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
  );

  sha_engine u_engine (
    .clk, .rst_n, .q_empty, .q_data(q_rdata), .q_pop,
    .out_valid, .out_ready, .out_data
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("output dropped while stalled");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_word) |=>
      (out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1))
    else $error("digest word skipped");
  a_last_only7: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last flag mismatch");
`endif
endmodule

FILE: rtl/core/sha_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts requests, counts message bytes and expands a finish request into
// the padding and length bytes, one queue entry per cycle while the queue has room.
// ----------------------------------------------------------------------------
module sha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sha_pkg::in_item_t in_data,
  output logic              q_push,
  output sha_pkg::byte_op_t q_data,
  input  logic              q_full
);
  import sha_pkg::*;

  typedef enum logic [1:0] {S_DATA, S_ZERO, S_LEN} state_t;

  state_t      state_r, state_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [2:0]  len_idx_r, len_idx_nxt;
  logic [5:0]  pos;

  assign pos      = cnt_r[5:0];
  assign in_ready = (state_r == S_DATA) && !q_full;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    bits_nxt    = bits_r;
    len_idx_nxt = len_idx_r;
    q_push      = 1'b0;
    q_data      = '0;
    case (state_r)
      S_DATA: begin
        if (in_valid && !q_full) begin
          q_push = 1'b1;
          cnt_nxt = cnt_r + 61'd1;
          q_data.end_block = (pos == 6'd63);
          if (in_data.command == CMD_ABSORB) begin
            q_data.byte_val = in_data.data_byte;
          end else begin
            q_data.byte_val = 8'h80;
            bits_nxt = {cnt_r, 3'b000};
            len_idx_nxt = 3'd0;
            state_nxt = (pos == 6'd55) ? S_LEN : S_ZERO;
          end
        end
      end
      S_ZERO: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_data.byte_val = 8'h00;
          q_data.end_block = (pos == 6'd63);
          cnt_nxt = cnt_r + 61'd1;
          if (pos == 6'd55) state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_data.byte_val = bits_r[63:56];
          bits_nxt = {bits_r[55:0], 8'h00};
          len_idx_nxt = len_idx_r + 3'd1;
          if (len_idx_r == 3'd7) begin
            q_data.end_block = 1'b1;
            q_data.end_msg = 1'b1;
            cnt_nxt = '0;
            state_nxt = S_DATA;
          end else begin
            cnt_nxt = cnt_r + 61'd1;
          end
        end
      end
      default: state_nxt = S_DATA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_DATA;
      cnt_r     <= '0;
      len_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      len_idx_r <= len_idx_nxt;
    end
    bits_r <= bits_nxt;
  end

`ifndef SYNTHESIS
  a_len_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_data.end_msg) |-> (pos == 6'd63))
    else $error("message end off block boundary");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DATA) |-> !in_ready)
    else $error("ready while padding");
  a_len_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEN && $past(state_r) != S_LEN) |-> (len_idx_r == 3'd0))
    else $error("length index not cleared");
`endif
endmodule

FILE: rtl/core/sha_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte queue
// Small FIFO between the front end and the compression engine.
// ----------------------------------------------------------------------------
module sha_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sha_pkg::byte_op_t push_data,
  output logic              full,
  input  logic              pop,
  output sha_pkg::byte_op_t pop_data,
  output logic              empty
);
  import sha_pkg::*;

  byte_op_t           mem_r [QDepth];
  logic [QIdxW-1:0]   wp_r, rp_r;
  logic [QIdxW:0]     cnt_r;

  assign full     = (cnt_r == (QIdxW+1)'(QDepth));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QIdxW+1)'(push && !full) - (QIdxW+1)'(pop && !empty);
    end
    if (push && !full) mem_r[wp_r] <= push_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QIdxW+1)'(QDepth))
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif
endmodule

FILE: rtl/core/sha_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Packs bytes into the 16-word schedule window, runs one round per cycle
// and emits the digest words after the final block.
// ----------------------------------------------------------------------------
module sha_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  sha_pkg::byte_op_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sha_pkg::out_item_t out_data
);
  import sha_pkg::*;

  typedef enum logic [1:0] {S_FILL, S_ROUND, S_ADD, S_EMIT} state_t;

  state_t       state_r;
  logic [31:0]  w_r [16];
  logic [31:0]  h_r [8];
  logic [31:0]  v_r [8];
  logic [3:0]   bw_r;      // word index within the 16-word window, 0..15
  logic [1:0]   bsub_r;
  logic [5:0]   rnd_r;
  logic         final_r;
  logic [2:0]   oidx_r;
  logic         ov_r;

  logic [31:0]  wv, w2, w15, s0, s1, t1, t2, ep1, ep0, ch, mj, a, e;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign q_pop     = (state_r == S_FILL) && !q_empty;
  assign out_valid = ov_r;
  assign out_data.digest_word = h_r[oidx_r];
  assign out_data.word_index  = oidx_r;
  assign out_data.last_word   = (oidx_r == 3'd7);

  // During the rounds w_r[0] holds W[r]; the window shifts one word per round.
  always_comb begin
    w2  = w_r[14];
    w15 = w_r[1];
    s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    wv  = s1 + w_r[9] + s0 + w_r[0];
    a   = v_r[0];
    e   = v_r[4];
    ep1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ep0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    ch  = (e & v_r[5]) ^ (~e & v_r[6]);
    mj  = (a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1  = v_r[7] + ep1 + ch + round_k(rnd_r) + w_r[0];
    t2  = ep0 + mj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      bw_r    <= '0;
      bsub_r  <= '0;
      rnd_r   <= '0;
      final_r <= 1'b0;
      oidx_r  <= '0;
      ov_r    <= 1'b0;
      for (int j = 0; j < 8; j++) h_r[j] <= init_h(3'(j));
    end else begin
      case (state_r)
        S_FILL: begin
          if (!q_empty) begin
            w_r[bw_r] <= {w_r[bw_r][23:0], q_data.byte_val};
            bsub_r <= bsub_r + 2'd1;
            if (bsub_r == 2'd3) bw_r <= bw_r + 4'd1;
            if (q_data.end_block) begin
              final_r <= q_data.end_msg;
              rnd_r   <= '0;
              for (int j = 0; j < 8; j++) v_r[j] <= h_r[j];
              state_r <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          for (int j = 0; j < 15; j++) w_r[j] <= w_r[j+1];
          w_r[15] <= wv;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= S_ADD;
        end
        S_ADD: begin
          for (int j = 0; j < 8; j++) h_r[j] <= h_r[j] + v_r[j];
          bw_r   <= '0;
          bsub_r <= '0;
          if (final_r) begin
            oidx_r  <= '0;
            ov_r    <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_FILL;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              ov_r    <= 1'b0;
              state_r <= S_FILL;
              for (int j = 0; j < 8; j++) h_r[j] <= init_h(3'(j));
            end
          end
        end
        default: state_r <= S_FILL;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_EMIT))
    else $error("output valid outside emit");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_word) |=> !out_valid)
    else $error("valid after last word");
  a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && $past(state_r) == S_FILL) |-> (rnd_r == 6'd0))
    else $error("round counter not cleared");
`endif
endmodule

FILE: bench/tb_sha256_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams messages of absorb requests closed by finish requests, predicts each
// digest with a behavioral SHA-256 and checks every digest word in order.
// ----------------------------------------------------------------------------

class digest_board;
  sha_pkg::out_item_t pending_words[$];
  logic [31:0] chain[8];
  logic [7:0]  blk[64];
  logic [60:0] nbytes;
  int          errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) chain[i] = sha_pkg::init_h(i[2:0]);
    nbytes = '0;
  endfunction

  static function logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, kc;
    for (int r = 0; r < 16; r++)
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    for (int r = 16; r < 64; r++)
      w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
           + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
    for (int j = 0; j < 8; j++) v[j] = chain[j];
    for (int r = 0; r < 64; r++) begin
      kc = constant_k(r);
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kc + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] += v[j];
  endfunction

  // Own table, same values as the standard round constants.
  static function logic [31:0] constant_k(int r);
    logic [31:0] tbl[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return tbl[r];
  endfunction

  function void push_byte(logic [7:0] b);
    logic [5:0] pos;
    pos = nbytes[5:0];
    blk[pos] = b;
    nbytes = nbytes + 61'd1;
    if (pos == 6'd63) compress_block();
  endfunction

  function void note_request(sha_pkg::in_item_t req);
    logic [63:0] bits;
    sha_pkg::out_item_t w;
    if (req.command == sha_pkg::CMD_ABSORB) begin
      push_byte(req.data_byte);
      return;
    end
    bits = {nbytes, 3'b000};
    push_byte(8'h80);
    while (nbytes[5:0] != 6'd56) push_byte(8'h00);
    for (int i = 0; i < 8; i++) push_byte(bits[63-8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      w.digest_word = chain[i];
      w.word_index  = i[2:0];
      w.last_word   = (i == 7);
      pending_words.push_back(w);
    end
    restart();
  endfunction

  function void check_word(sha_pkg::out_item_t got);
    sha_pkg::out_item_t exp_w;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected digest word, actual %h", $time, got);
      errors++;
      return;
    end
    exp_w = pending_words.pop_front();
    if (got.digest_word !== exp_w.digest_word) begin
      $display("%0t: digest_word expected %h actual %h", $time,
               exp_w.digest_word, got.digest_word);
      errors++;
    end
    if (got.word_index !== exp_w.word_index) begin
      $display("%0t: word_index expected %0d actual %0d", $time,
               exp_w.word_index, got.word_index);
      errors++;
    end
    if (got.last_word !== exp_w.last_word) begin
      $display("%0t: last_word expected %0b actual %0b", $time,
               exp_w.last_word, got.last_word);
      errors++;
    end
  endfunction
endclass

module tb_sha256_stream_hasher;
  import sha_pkg::*;

  // Padding of up to 72 bytes plus two compressions, and a stalled receiver,
  // must fit within the idle limit. Leave wide margin.
  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  digest_board board = new();
  bit quiet = 1'b0;   // long stretch with no idling on either side
  int stall_cycles = 0;

  always #1 clk = ~clk;

  sha256_stream_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Receiver: random back-pressure, check on each accepted word.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_word(out_data);
    out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 7);
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
      stall_cycles <= 0;
    else if (rst_n)
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one request and hold it until accepted; random idle before it.
  task automatic send_request(input logic cmd, input logic [7:0] b);
    in_item_t req;
    req.command = cmd;
    req.data_byte = b;
    while (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(req);
  endtask

  task automatic send_message(input int len, input int mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_request(CMD_ABSORB, b);
    end
    send_request(CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_words.size() != 0) @(posedge clk);
  endtask

  int sent;
  int len;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, "abc", all-zero and all-ones bytes, then a
    // finish whose ignored data byte is zero.
    send_message(0, 2);
    send_request(CMD_ABSORB, 8'h61);
    send_request(CMD_ABSORB, 8'h62);
    send_request(CMD_ABSORB, 8'h63);
    send_request(CMD_FINISH, 8'hff);
    send_message(3, 0);
    send_message(5, 1);
    send_request(CMD_FINISH, 8'h00);
    // Sender holds off until every digest word is back.
    wait_drained();

    // Random: lengths around block edges (55, 56, 63 to 65) mostly short.
    sent = 0;
    while (sent < 250) begin
      quiet = (sent >= 100 && sent < 160);
      case ($urandom_range(0, 5))
        0: len = $urandom_range(55, 56);
        1: len = $urandom_range(63, 65);
        2: len = $urandom_range(0, 2);
        default: len = $urandom_range(0, 30);
      endcase
      send_message(len, ($urandom_range(0, 9) == 0) ? 1 : 2);
      sent += len + 1;
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.errors == 0 && board.pending_words.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
